@@ rtl/b64_pkg.sv @@
// shared constants, group type and alphabet lookup for the base64 encoder
`default_nettype none

package b64_pkg;

   localparam int BYTE_W = 8;
   localparam int CHAR_W = 7;
   localparam int SEXTET_W = 6;
   localparam int PHASE_W = 2;
   localparam int IDX_W = 2;
   localparam int QUEUE_DEPTH_DEF = 2;

   // bytes already held in the current group
   localparam logic [PHASE_W-1:0] PHASE_ZERO = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_ONE  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TWO  = 2'd2;

   // character slots of one group
   localparam logic [IDX_W-1:0] IDX_FIRST  = 2'd0;
   localparam logic [IDX_W-1:0] IDX_SECOND = 2'd1;
   localparam logic [IDX_W-1:0] IDX_THIRD  = 2'd2;
   localparam logic [IDX_W-1:0] IDX_LAST   = 2'd3;

   localparam logic [CHAR_W-1:0] PAD_CODE   = 7'd61;
   localparam logic [CHAR_W-1:0] PLUS_CODE  = 7'd43;
   localparam logic [CHAR_W-1:0] SLASH_CODE = 7'd47;
   localparam logic [CHAR_W-1:0] UPPER_OFS  = 7'd65;
   localparam logic [CHAR_W-1:0] LOWER_OFS  = 7'd71;
   localparam logic [CHAR_W-1:0] DIGIT_OFS  = 7'd4;

   typedef struct packed {
      logic [BYTE_W-1:0]  grp_b0;
      logic [BYTE_W-1:0]  grp_b1;
      logic [BYTE_W-1:0]  grp_b2;
      logic [PHASE_W-1:0] held;
      logic               fin;
   } group_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] vx;
      vx = {1'b0, v};
      if (v < 6'd26) begin
         c = UPPER_OFS + vx;
      end else if (v < 6'd52) begin
         c = LOWER_OFS + vx;
      end else if (v < 6'd62) begin
         // digits: '0' sits 4 below the sextet value 52
         c = vx - DIGIT_OFS;
      end else if (v == 6'd62) begin
         c = PLUS_CODE;
      end else begin
         c = SLASH_CODE;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/b64_req_if.sv @@
// byte channel into the encoder
`default_nettype none

interface b64_req_if;
   import b64_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);

endinterface

`default_nettype wire

@@ rtl/b64_rsp_if.sv @@
// character channel out of the encoder
`default_nettype none

interface b64_rsp_if;
   import b64_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);

endinterface

`default_nettype wire

@@ rtl/b64_front.sv @@
// front end: collects bytes into groups of up to three and queues each group
`default_nettype none

module b64_front (
   input  wire logic          clock,
   input  wire logic          reset,
   b64_req_if.sink            req,
   output logic               push_valid,
   input  wire logic          push_ready,
   output b64_pkg::group_type push_grp
);
   import b64_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  pend0_ff, pend0_in;
   logic [BYTE_W-1:0]  pend1_ff, pend1_in;
   logic               accept;
   logic               close_grp;
   logic [PHASE_W-1:0] phase_eff;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      case (phase_ff)
         PHASE_ONE: phase_eff = PHASE_ONE;
         PHASE_TWO: phase_eff = PHASE_TWO;
         default:   phase_eff = PHASE_ZERO;
      endcase
   end

   assign close_grp  = req.final_byte || (phase_eff == PHASE_TWO);
   assign push_valid = accept && close_grp;

   // held bytes first, the incoming word next, zero fill after
   always_comb begin
      push_grp.held = phase_eff;
      push_grp.fin  = req.final_byte;
      push_grp.grp_b0 = (phase_eff == PHASE_ZERO) ? req.data_byte : pend0_ff;
      case (phase_eff)
         PHASE_ONE: push_grp.grp_b1 = req.data_byte;
         PHASE_TWO: push_grp.grp_b1 = pend1_ff;
         default:   push_grp.grp_b1 = '0;
      endcase
      push_grp.grp_b2 = (phase_eff == PHASE_TWO) ? req.data_byte : '0;
   end

   always_comb begin
      phase_in = phase_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (close_grp) begin
            phase_in = PHASE_ZERO;
         end else begin
            phase_in = phase_eff + PHASE_ONE;
            if (phase_eff == PHASE_ZERO) begin
               pend0_in = req.data_byte;
            end else begin
               pend1_in = req.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_ZERO;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

`default_nettype wire

@@ rtl/b64_queue.sv @@
// short group queue between front and back end
`default_nettype none

module b64_queue #(
   parameter int DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire b64_pkg::group_type  push_grp,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output b64_pkg::group_type       pop_grp
);
   import b64_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_grp    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_END) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_END) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule

`default_nettype wire

@@ rtl/b64_back.sv @@
// back end: turns one queued group into four characters, one per cycle while the result channel is ready
`default_nettype none

module b64_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire b64_pkg::group_type  pop_grp,
   b64_rsp_if.source                rsp
);
   import b64_pkg::*;

   group_type          cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  code_ff, code_in;
   logic               last_ff, last_in;
   logic               advance;
   logic               step;
   logic               finish;
   logic [SEXTET_W-1:0] s0, s1, s2, s3;
   logic [CHAR_W-1:0]  sel_code;
   logic               sel_last;

   assign advance   = !out_valid_ff || rsp.ready;
   assign step      = busy_ff && advance;
   assign finish    = step && (idx_ff == IDX_LAST);
   assign pop_ready = !busy_ff || finish;

   assign s0 = cur_ff.grp_b0[7:2];
   assign s1 = {cur_ff.grp_b0[1:0], cur_ff.grp_b1[7:4]};
   assign s2 = {cur_ff.grp_b1[3:0], cur_ff.grp_b2[7:6]};
   assign s3 = cur_ff.grp_b2[5:0];

   always_comb begin
      sel_last = 1'b0;
      case (idx_ff)
         IDX_FIRST:  sel_code = sextet_char(s0);
         IDX_SECOND: sel_code = sextet_char(s1);
         IDX_THIRD: begin
            sel_code = (cur_ff.held == PHASE_ZERO) ? PAD_CODE : sextet_char(s2);
         end
         IDX_LAST: begin
            sel_code = (cur_ff.held == PHASE_TWO) ? sextet_char(s3) : PAD_CODE;
            // a short group only ever closes the message
            sel_last = (cur_ff.held != PHASE_TWO) || cur_ff.fin;
         end
         default: sel_code = PAD_CODE;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = step;
      end
      if (step) begin
         code_in = sel_code;
         last_in = sel_last;
         idx_in  = idx_ff + IDX_W'(1);
      end
      if (finish) begin
         busy_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         cur_in  = pop_grp;
         idx_in  = IDX_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= IDX_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.char_code = code_ff;
   assign rsp.last_char = last_ff;

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
// top level of the streaming base64 encoder
//
//   channel    dir   payload                       handshake
//   req_chan   in    data_byte[7:0], final_byte    valid / ready
//   rsp_chan   out   char_code[6:0], last_char     valid / ready
//
// one byte is taken per cycle while the group queue has room; bytes that
// open or extend a group leave no result.
// a closed group yields four characters at one per cycle through the output
// register while rsp_chan is ready, so the sustained rate is set by the
// single-character result channel.
// reset is synchronous and clears the group phase, the queue and the output.
// a stalled result channel fills the back end and the queue of QUEUE_DEPTH
// groups, then req_chan.ready stays low for every word until a group leaves.
`default_nettype none

module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   b64_req_if.sink   req_chan,
   b64_rsp_if.source rsp_chan
);
   import b64_pkg::*;

   logic      push_valid;
   logic      push_ready;
   group_type push_grp;
   logic      pop_valid;
   logic      pop_ready;
   group_type pop_grp;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_grp   (push_grp)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_grp   (push_grp),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_grp    (pop_grp)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_grp   (pop_grp),
      .rsp       (rsp_chan)
   );

   // a partial group is only ever sent on the final word
   a_short_push_final: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_grp.held == PHASE_TWO) || push_grp.fin)
      else $error("partial group pushed without final flag");

   a_short_pop_final: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (pop_grp.held == PHASE_TWO) || pop_grp.fin)
      else $error("partial group left queue without final flag");

   // a pushed group leaves the queue non-empty on the next cycle
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_ready |=> pop_valid)
      else $error("pushed group missing from queue");

endmodule

`default_nettype wire
